// ===== design/wcm_pkg.sv =====
`default_nettype none
package wcm_pkg;

  // Field widths
  localparam int SIZE_W = 17;
  localparam int IN_W   = 18;
  localparam int OUT_W  = 24;
  localparam int PROD_W = 36;   // signed point times unsigned size
  localparam int CROSS_W = 2 * SIZE_W;
  localparam int NUM_W  = 38;   // fit numerator, signed
  localparam int DEN_W  = SIZE_W + 1;

  // Divider layout: quotient magnitude bits, two bits retired per stage
  localparam int QBITS      = OUT_W;
  localparam int STEPS      = 2;
  localparam int DIV_STAGES = QBITS / STEPS;

  // Register indexes
  localparam logic [2:0] REG_VIRT_W  = 3'd0;
  localparam logic [2:0] REG_VIRT_H  = 3'd1;
  localparam logic [2:0] REG_MODE    = 3'd2;
  localparam logic [2:0] REG_FRAME_W = 3'd3;
  localparam logic [2:0] REG_FRAME_H = 3'd4;

  // Scale modes (code three behaves as pixel)
  localparam logic [1:0] MODE_STRETCH = 2'd0;
  localparam logic [1:0] MODE_FIT     = 2'd1;
  localparam logic [1:0] MODE_PIXEL   = 2'd2;

  localparam logic [OUT_W-1:0] OUT_MAX = 24'h7FFFFF;
  localparam logic [OUT_W-1:0] OUT_MIN = 24'h800000;

  // One divider lane in flight
  typedef struct packed {
    logic [DEN_W-1:0] rem;   // partial remainder, always below den
    logic [QBITS-1:0] bits;  // dividend bits still to shift in, quotient shifts in below
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             sat;
  } lane_t;

endpackage
`default_nettype wire

// ===== design/wcm_div_stage.sv =====
`default_nettype none
module wcm_div_stage (
  input  wcm_pkg::lane_t d_i,
  output wcm_pkg::lane_t d_o
);

  logic [wcm_pkg::DEN_W-1:0] rem_v;
  logic [wcm_pkg::DEN_W:0]   trial_v;
  logic [wcm_pkg::QBITS-1:0] bits_v;

  // Restoring division, two quotient bits per stage
  always_comb begin
    rem_v   = d_i.rem;
    bits_v  = d_i.bits;
    trial_v = '0;
    for (int k = 0; k < wcm_pkg::STEPS; k++) begin
      trial_v = {rem_v, bits_v[wcm_pkg::QBITS-1]};
      bits_v  = {bits_v[wcm_pkg::QBITS-2:0], 1'b0};
      if (trial_v >= {1'b0, d_i.den}) begin
        trial_v   = trial_v - {1'b0, d_i.den};
        bits_v[0] = 1'b1;
      end
      rem_v = trial_v[wcm_pkg::DEN_W-1:0];
    end
    d_o      = d_i;
    d_o.rem  = rem_v;
    d_o.bits = bits_v;
  end

endmodule
`default_nettype wire

// ===== design/window_to_canvas_mapper_unit.sv =====
`default_nettype none
// Window to canvas point mapper. Each request (window_x, window_y, signed Q13.4)
// gives one result: canvas coordinates in signed Q19.4, truncated toward zero
// and saturated, an inside flag against the resolved canvas size and a size
// error flag for a zero framebuffer size in stretch or fit mode. One request
// is taken every cycle unless the output stalls; it passes two multiply stages, one
// numerator stage, twelve divider stages of two quotient bits each and the
// output register. Configuration is written through cfg_we/cfg_index/cfg_wdata
// and must only change while no request is in flight.
module window_to_canvas_mapper_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_index,
  input  wire logic [wcm_pkg::SIZE_W-1:0]   cfg_wdata,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [wcm_pkg::IN_W-1:0] in_window_x,
  input  wire logic signed [wcm_pkg::IN_W-1:0] in_window_y,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [wcm_pkg::OUT_W-1:0]  out_canvas_x,
  output logic signed [wcm_pkg::OUT_W-1:0]  out_canvas_y,
  output logic                              out_inside_res,
  output logic                              out_size_error
);

  localparam int LAST = wcm_pkg::DIV_STAGES - 1;

  // Configuration registers
  logic [wcm_pkg::SIZE_W-1:0] vw_r, vh_r, fw_r, fh_r;
  logic [1:0]                 mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vw_r   <= '0;
      vh_r   <= '0;
      fw_r   <= '0;
      fh_r   <= '0;
      mode_r <= wcm_pkg::MODE_PIXEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wcm_pkg::REG_VIRT_W:  vw_r   <= cfg_wdata;
        wcm_pkg::REG_VIRT_H:  vh_r   <= cfg_wdata;
        wcm_pkg::REG_MODE:    mode_r <= cfg_wdata[1:0];
        wcm_pkg::REG_FRAME_W: fw_r   <= cfg_wdata;
        wcm_pkg::REG_FRAME_H: fh_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Resolved sizes and mode decode
  logic [wcm_pkg::SIZE_W-1:0] rw, rh;
  logic is_stretch, is_fit, size_bad;
  assign rw         = (vw_r != '0) ? vw_r : fw_r;
  assign rh         = (vh_r != '0) ? vh_r : fh_r;
  assign is_stretch = (mode_r == wcm_pkg::MODE_STRETCH);
  assign is_fit     = (mode_r == wcm_pkg::MODE_FIT);
  assign size_bad   = (is_stretch || is_fit) && (fw_r == '0 || fh_r == '0);

  // Pipeline valids and per-stage ready
  logic a_v_r, b_v_r, c_v_r, out_valid_r;
  logic [wcm_pkg::DIV_STAGES-1:0] dv_v_r;
  logic a_rdy, b_rdy, c_rdy, o_rdy;
  logic [wcm_pkg::DIV_STAGES-1:0] d_rdy;

  always_comb begin
    o_rdy = !out_valid_r || out_ready;
    d_rdy[LAST] = !dv_v_r[LAST] || o_rdy;
    for (int i = LAST - 1; i >= 0; i--) begin
      d_rdy[i] = !dv_v_r[i] || d_rdy[i+1];
    end
    c_rdy = !c_v_r || d_rdy[0];
    b_rdy = !b_v_r || c_rdy;
    a_rdy = !a_v_r || b_rdy;
  end
  assign in_ready = a_rdy;

  // Stage A: cross products that pick the fit axis
  logic signed [wcm_pkg::IN_W-1:0] a_wx_r, a_wy_r;
  logic [wcm_pkg::CROSS_W-1:0]     a_cfw_r, a_cfh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_rdy) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_rdy) begin
      a_wx_r  <= in_window_x;
      a_wy_r  <= in_window_y;
      a_cfw_r <= fw_r * rh;
      a_cfh_r <= fh_r * rw;
    end
  end

  // Stage B: scale products
  logic [wcm_pkg::SIZE_W-1:0] fn, fd, dx, dy;
  assign fn = (a_cfw_r < a_cfh_r) ? fw_r : fh_r;
  assign fd = (a_cfw_r < a_cfh_r) ? rw : rh;
  assign dx = is_stretch ? rw : fd;
  assign dy = is_stretch ? rh : fd;

  logic signed [wcm_pkg::IN_W-1:0]   b_wx_r, b_wy_r;
  logic signed [wcm_pkg::PROD_W-1:0] b_pwx_r, b_pwy_r;
  logic [wcm_pkg::CROSS_W-1:0]       b_fdx_r, b_fdy_r, b_rnx_r, b_rny_r;
  logic [wcm_pkg::SIZE_W-1:0]        b_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_rdy) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_rdy) begin
      b_wx_r  <= a_wx_r;
      b_wy_r  <= a_wy_r;
      b_pwx_r <= a_wx_r * $signed({1'b0, dx});
      b_pwy_r <= a_wy_r * $signed({1'b0, dy});
      b_fdx_r <= fw_r * fd;
      b_fdy_r <= fh_r * fd;
      b_rnx_r <= rw * fn;
      b_rny_r <= rh * fn;
      b_n_r   <= fn;
    end
  end

  // Stage C: numerator, divisor, magnitude and overflow check
  logic signed [wcm_pkg::NUM_W-1:0] num_x, num_y;
  logic [wcm_pkg::DEN_W-1:0]        den_x, den_y;
  logic [wcm_pkg::NUM_W-1:0]        mag_x, mag_y;
  wcm_pkg::lane_t                   c_x_nxt, c_y_nxt;

  always_comb begin
    if (is_stretch) begin
      num_x = {{(wcm_pkg::NUM_W-wcm_pkg::PROD_W){b_pwx_r[wcm_pkg::PROD_W-1]}}, b_pwx_r};
      num_y = {{(wcm_pkg::NUM_W-wcm_pkg::PROD_W){b_pwy_r[wcm_pkg::PROD_W-1]}}, b_pwy_r};
      den_x = {1'b0, fw_r};
      den_y = {1'b0, fh_r};
    end else if (is_fit) begin
      num_x = ({{(wcm_pkg::NUM_W-wcm_pkg::PROD_W){b_pwx_r[wcm_pkg::PROD_W-1]}}, b_pwx_r} <<< 1)
            - $signed({4'b0, b_fdx_r}) + $signed({4'b0, b_rnx_r});
      num_y = ({{(wcm_pkg::NUM_W-wcm_pkg::PROD_W){b_pwy_r[wcm_pkg::PROD_W-1]}}, b_pwy_r} <<< 1)
            - $signed({4'b0, b_fdy_r}) + $signed({4'b0, b_rny_r});
      den_x = {b_n_r, 1'b0};
      den_y = {b_n_r, 1'b0};
    end else begin
      num_x = {{(wcm_pkg::NUM_W-wcm_pkg::IN_W){b_wx_r[wcm_pkg::IN_W-1]}}, b_wx_r};
      num_y = {{(wcm_pkg::NUM_W-wcm_pkg::IN_W){b_wy_r[wcm_pkg::IN_W-1]}}, b_wy_r};
      den_x = wcm_pkg::DEN_W'(1);
      den_y = wcm_pkg::DEN_W'(1);
    end
    // keep the divider sane when the result is forced to zero anyway
    if (size_bad) begin
      den_x = wcm_pkg::DEN_W'(1);
      den_y = wcm_pkg::DEN_W'(1);
    end
    mag_x = num_x[wcm_pkg::NUM_W-1] ? 38'(-num_x) : 38'(num_x);
    mag_y = num_y[wcm_pkg::NUM_W-1] ? 38'(-num_y) : 38'(num_y);

    c_x_nxt.neg  = num_x[wcm_pkg::NUM_W-1];
    c_x_nxt.den  = den_x;
    c_x_nxt.sat  = {4'b0, mag_x} >= {den_x, {wcm_pkg::QBITS{1'b0}}};
    c_x_nxt.rem  = {4'b0, mag_x[wcm_pkg::NUM_W-1:wcm_pkg::QBITS]};
    c_x_nxt.bits = mag_x[wcm_pkg::QBITS-1:0];
    c_y_nxt.neg  = num_y[wcm_pkg::NUM_W-1];
    c_y_nxt.den  = den_y;
    c_y_nxt.sat  = {4'b0, mag_y} >= {den_y, {wcm_pkg::QBITS{1'b0}}};
    c_y_nxt.rem  = {4'b0, mag_y[wcm_pkg::NUM_W-1:wcm_pkg::QBITS]};
    c_y_nxt.bits = mag_y[wcm_pkg::QBITS-1:0];
    // saturated lanes skip the division result
    if (c_x_nxt.sat) begin
      c_x_nxt.rem = '0;
    end
    if (c_y_nxt.sat) begin
      c_y_nxt.rem = '0;
    end
  end

  wcm_pkg::lane_t c_x_r, c_y_r;
  logic           c_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (c_rdy) begin
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (c_rdy) begin
      c_x_r   <= c_x_nxt;
      c_y_r   <= c_y_nxt;
      c_err_r <= size_bad;
    end
  end

  // Divider stages, two lanes side by side
  wcm_pkg::lane_t dx_r [wcm_pkg::DIV_STAGES];
  wcm_pkg::lane_t dy_r [wcm_pkg::DIV_STAGES];
  wcm_pkg::lane_t dx_nxt [wcm_pkg::DIV_STAGES];
  wcm_pkg::lane_t dy_nxt [wcm_pkg::DIV_STAGES];
  logic [wcm_pkg::DIV_STAGES-1:0] derr_r;

  for (genvar g = 0; g < wcm_pkg::DIV_STAGES; g++) begin : g_div
    if (g == 0) begin : g_first
      wcm_div_stage u_sx (.d_i(c_x_r), .d_o(dx_nxt[g]));
      wcm_div_stage u_sy (.d_i(c_y_r), .d_o(dy_nxt[g]));
    end else begin : g_rest
      wcm_div_stage u_sx (.d_i(dx_r[g-1]), .d_o(dx_nxt[g]));
      wcm_div_stage u_sy (.d_i(dy_r[g-1]), .d_o(dy_nxt[g]));
    end
  end

  // Divider valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r <= '0;
    end else begin
      if (d_rdy[0]) begin
        dv_v_r[0] <= c_v_r;
      end
      for (int i = 1; i < wcm_pkg::DIV_STAGES; i++) begin
        if (d_rdy[i]) begin
          dv_v_r[i] <= dv_v_r[i-1];
        end
      end
    end
  end

  // Divider data chain
  always_ff @(posedge clk) begin
    if (d_rdy[0]) begin
      dx_r[0]   <= dx_nxt[0];
      dy_r[0]   <= dy_nxt[0];
      derr_r[0] <= c_err_r;
    end
    for (int i = 1; i < wcm_pkg::DIV_STAGES; i++) begin
      if (d_rdy[i]) begin
        dx_r[i]   <= dx_nxt[i];
        dy_r[i]   <= dy_nxt[i];
        derr_r[i] <= derr_r[i-1];
      end
    end
  end

  // Output: sign, saturation and inside test
  logic [wcm_pkg::OUT_W-1:0] cx_v, cy_v;
  logic                      inside_v;

  always_comb begin
    if (!dx_r[LAST].neg) begin
      cx_v = (dx_r[LAST].sat || dx_r[LAST].bits[wcm_pkg::QBITS-1]) ? wcm_pkg::OUT_MAX
           : dx_r[LAST].bits;
    end else begin
      cx_v = (dx_r[LAST].sat || dx_r[LAST].bits > wcm_pkg::OUT_MIN) ? wcm_pkg::OUT_MIN
           : ~dx_r[LAST].bits + 1'b1;
    end
    if (!dy_r[LAST].neg) begin
      cy_v = (dy_r[LAST].sat || dy_r[LAST].bits[wcm_pkg::QBITS-1]) ? wcm_pkg::OUT_MAX
           : dy_r[LAST].bits;
    end else begin
      cy_v = (dy_r[LAST].sat || dy_r[LAST].bits > wcm_pkg::OUT_MIN) ? wcm_pkg::OUT_MIN
           : ~dy_r[LAST].bits + 1'b1;
    end
    inside_v = !cx_v[wcm_pkg::OUT_W-1] && (cx_v[wcm_pkg::OUT_W-2:0] < {6'b0, rw})
            && !cy_v[wcm_pkg::OUT_W-1] && (cy_v[wcm_pkg::OUT_W-2:0] < {6'b0, rh});
    if (derr_r[LAST]) begin
      cx_v     = '0;
      cy_v     = '0;
      inside_v = 1'b0;
    end
  end

  logic [wcm_pkg::OUT_W-1:0] out_cx_r, out_cy_r;
  logic                      out_inside_r, out_err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_rdy) begin
      out_valid_r <= dv_v_r[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy) begin
      out_cx_r     <= cx_v;
      out_cy_r     <= cy_v;
      out_inside_r <= inside_v;
      out_err_r    <= derr_r[LAST];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_canvas_x   = $signed(out_cx_r);
  assign out_canvas_y   = $signed(out_cy_r);
  assign out_inside_res = out_inside_r;
  assign out_size_error = out_err_r;

  // Assertions
  for (genvar g = 0; g < wcm_pkg::DIV_STAGES; g++) begin : g_chk
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
      dv_v_r[g] |-> (dx_r[g].rem < dx_r[g].den) && (dy_r[g].rem < dy_r[g].den))
      else $error("divider remainder not below divisor");
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_err_r |-> out_cx_r == '0 && out_cy_r == '0 && !out_inside_r)
    else $error("size error result not cleared");

  a_inside_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_inside_r |-> !out_cx_r[wcm_pkg::OUT_W-1] && !out_cy_r[wcm_pkg::OUT_W-1])
    else $error("inside flag with negative coordinate");

  a_tail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v_r[LAST] && !o_rdy |=> dv_v_r[LAST] && $stable(dx_r[LAST]) && $stable(dy_r[LAST]))
    else $error("divider tail lost during stall");

endmodule
`default_nettype wire

// ===== test/wcm_checker.sv =====
module wcm_checker (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [2:0]                       cfg_index,
  input  wire logic [wcm_pkg::SIZE_W-1:0]       cfg_wdata,
  input  wire logic                             in_valid,
  input  wire logic                             in_ready,
  input  wire logic signed [wcm_pkg::IN_W-1:0]  in_window_x,
  input  wire logic signed [wcm_pkg::IN_W-1:0]  in_window_y,
  input  wire logic                             out_valid,
  input  wire logic                             out_ready,
  input  wire logic signed [wcm_pkg::OUT_W-1:0] out_canvas_x,
  input  wire logic signed [wcm_pkg::OUT_W-1:0] out_canvas_y,
  input  wire logic                             out_inside_res,
  input  wire logic                             out_size_error,
  output int                                    fail_count,
  output int                                    pending
);

  typedef struct packed {
    logic signed [wcm_pkg::OUT_W-1:0] cx;
    logic signed [wcm_pkg::OUT_W-1:0] cy;
    logic                             in_rect;
    logic                             err;
  } canvas_pt_t;

  // shadow registers
  logic [wcm_pkg::SIZE_W-1:0] virt_w, virt_h, frame_w, frame_h;
  logic [1:0]                 mode;
  canvas_pt_t                 canvas_q[$];
  int                         mismatches;

  function automatic longint clamp_quot(longint num, longint den);
    longint q;
    q = num / den;
    if (q > 64'sd8388607) q = 64'sd8388607;
    if (q < -64'sd8388608) q = -64'sd8388608;
    return q;
  endfunction

  function automatic canvas_pt_t map_point(logic signed [wcm_pkg::IN_W-1:0] px,
                                           logic signed [wcm_pkg::IN_W-1:0] py);
    canvas_pt_t r;
    longint wx, wy, fw, fh, rw, rh, cx, cy, n, d;
    wx = px; wy = py;
    fw = frame_w; fh = frame_h;
    rw = (virt_w != 0) ? longint'(virt_w) : fw;
    rh = (virt_h != 0) ? longint'(virt_h) : fh;
    r = '0;
    if (mode == wcm_pkg::MODE_STRETCH || mode == wcm_pkg::MODE_FIT) begin
      if (fw == 0 || fh == 0) begin
        r.err = 1'b1;
        return r;
      end
      if (mode == wcm_pkg::MODE_STRETCH) begin
        cx = clamp_quot(wx * rw, fw);
        cy = clamp_quot(wy * rh, fh);
      end else begin
        // smaller ratio picked by cross-multiplication
        if (fw * rh < fh * rw) begin
          n = fw; d = rw;
        end else begin
          n = fh; d = rh;
        end
        cx = clamp_quot(2 * wx * d - fw * d + rw * n, 2 * n);
        cy = clamp_quot(2 * wy * d - fh * d + rh * n, 2 * n);
      end
    end else begin
      cx = wx; cy = wy;
    end
    r.cx = cx[wcm_pkg::OUT_W-1:0];
    r.cy = cy[wcm_pkg::OUT_W-1:0];
    r.in_rect = cx >= 0 && cx < rw && cy >= 0 && cy < rh;
    return r;
  endfunction

  assign pending    = canvas_q.size();
  assign fail_count = mismatches;

  always @(posedge clk) begin
    canvas_pt_t exp_pt, got;
    if (!rst_n) begin
      virt_w <= '0; virt_h <= '0; frame_w <= '0; frame_h <= '0;
      mode <= wcm_pkg::MODE_PIXEL;
      canvas_q.delete();
      mismatches <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          wcm_pkg::REG_VIRT_W:  virt_w <= cfg_wdata;
          wcm_pkg::REG_VIRT_H:  virt_h <= cfg_wdata;
          wcm_pkg::REG_MODE:    mode <= cfg_wdata[1:0];
          wcm_pkg::REG_FRAME_W: frame_w <= cfg_wdata;
          wcm_pkg::REG_FRAME_H: frame_h <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        canvas_q.push_back(map_point(in_window_x, in_window_y));
      if (out_valid && out_ready) begin
        got = {out_canvas_x, out_canvas_y, out_inside_res, out_size_error};
        if (canvas_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("ERROR: unexpected result %h", got);
        end else begin
          exp_pt = canvas_q.pop_front();
          if (got !== exp_pt) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("ERROR: x exp %0d got %0d, y exp %0d got %0d, in %b/%b, err %b/%b",
                       exp_pt.cx, got.cx, exp_pt.cy, got.cy, exp_pt.in_rect,
                       got.in_rect, exp_pt.err, got.err);
          end
        end
      end
    end
  end

endmodule

// ===== test/tb_window_to_canvas_mapper_unit.sv =====
module tb_window_to_canvas_mapper_unit;

  localparam int LATENCY = 16;
  localparam int IDLE_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [wcm_pkg::SIZE_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [wcm_pkg::IN_W-1:0] in_window_x = '0, in_window_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [wcm_pkg::OUT_W-1:0] out_canvas_x, out_canvas_y;
  logic out_inside_res, out_size_error;
  int fail_count, pending;
  logic hold_off = 1'b0;
  logic gen_done = 1'b0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  window_to_canvas_mapper_unit uut (.*);

  wcm_checker chk (.*);

  // receiver: own stall pattern plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(0, 9) < 7) || (($urandom & 32'h3f) == 0);
  end

  // watchdog on cycles without any request moving
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || hold_off)
      idle_cycles <= 0;
    else if (pending != 0 || !gen_done)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [wcm_pkg::SIZE_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [wcm_pkg::SIZE_W-1:0] vw, logic [wcm_pkg::SIZE_W-1:0] vh,
                            logic [1:0] md,
                            logic [wcm_pkg::SIZE_W-1:0] fw, logic [wcm_pkg::SIZE_W-1:0] fh);
    write_reg(wcm_pkg::REG_VIRT_W, vw);
    write_reg(wcm_pkg::REG_VIRT_H, vh);
    write_reg(wcm_pkg::REG_MODE, {{(wcm_pkg::SIZE_W-2){1'b0}}, md});
    write_reg(wcm_pkg::REG_FRAME_W, fw);
    write_reg(wcm_pkg::REG_FRAME_H, fh);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one request, valid held until accepted
  task automatic send_point(logic signed [wcm_pkg::IN_W-1:0] px,
                            logic signed [wcm_pkg::IN_W-1:0] py);
    in_valid <= 1'b1; in_window_x <= px; in_window_y <= py;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  function automatic logic signed [wcm_pkg::IN_W-1:0] rand_coord(
      logic [wcm_pkg::SIZE_W-1:0] lim);
    case ($urandom_range(0, 3))
      0: return 18'($urandom);
      1: return 18'($urandom_range(0, lim));
      2: return -$signed({1'b0, 17'($urandom_range(0, 64))});
      default: return ($urandom_range(0, 1)) ? 18'sh1FFFF : 18'sh20000;
    endcase
  endfunction

  function automatic logic [wcm_pkg::SIZE_W-1:0] rand_size();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 17'($urandom_range(1, 16));
      default: return 17'($urandom);
    endcase
  endfunction

  initial begin
    int burst;
    logic [wcm_pkg::SIZE_W-1:0] vw, vh, fw, fh;
    logic [1:0] md;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset config (pixel, zero sizes), then each mode at extremes
    send_point(18'sh1FFFF, 18'sh20000);
    send_point(0, 0);
    in_valid <= 1'b0;
    drain();
    set_config(17'd3200, 17'd1600, wcm_pkg::MODE_STRETCH, 17'd1600, 17'd1600);
    send_point(18'sh1FFFF, 18'sh20000);
    send_point(-1, 1);
    send_point(0, 18'sd1599);
    in_valid <= 1'b0;
    drain();
    set_config('1, '1, wcm_pkg::MODE_STRETCH, 17'd1, 17'd1);   // saturation
    send_point(18'sh1FFFF, 18'sh20000);
    in_valid <= 1'b0;
    drain();
    set_config(17'd1000, 17'd2000, wcm_pkg::MODE_FIT, 17'd800, 17'd900);
    send_point(0, 0);
    send_point(18'sd400, 18'sd450);
    send_point(18'sh20000, 18'sh1FFFF);
    in_valid <= 1'b0;
    drain();
    set_config(0, 0, wcm_pkg::MODE_FIT, 17'd640, 17'd480);       // follow frame size
    send_point(18'sd639, 18'sd479);
    send_point(18'sd640, 18'sd480);
    in_valid <= 1'b0;
    drain();
    set_config(0, 0, wcm_pkg::MODE_STRETCH, 0, 17'd10);          // size error
    send_point(5, 5);
    in_valid <= 1'b0;
    drain();
    set_config(17'd100, 0, wcm_pkg::MODE_FIT, 17'd10, 0);
    send_point(5, 5);
    in_valid <= 1'b0;
    drain();
    set_config(17'd100, 17'd100, 2'd3, 0, 0);                    // selector three
    send_point(18'sd50, -18'sd1);
    send_point(18'sd50, 18'sd99);
    in_valid <= 1'b0;
    drain();
    write_reg(3'd7, '1);                                         // out of range index
    send_point(18'sd50, 18'sd99);
    in_valid <= 1'b0;
    drain();

    // random phases
    for (int ph = 0; ph < 25; ph++) begin
      vw = rand_size(); vh = rand_size(); fw = rand_size(); fh = rand_size();
      md = 2'($urandom_range(0, 3));
      if (ph % 4 != 3) begin
        if (fw == 0) fw = 17'($urandom_range(1, 17'h1FFFF));
        if (fh == 0) fh = 17'($urandom_range(1, 17'h1FFFF));
      end
      set_config(vw, vh, md, fw, fh);
      if (ph == 5) hold_off <= 1'b1;
      for (int k = 0; k < 50; k += burst) begin
        burst = $urandom_range(1, 12);
        for (int j = 0; j < burst; j++)
          send_point(rand_coord(vw | fw), rand_coord(vh | fh));
        if (ph == 5 && k == 0) begin
          // long receiver hold-off while requests keep coming
          fork
            begin
              repeat (60) @(posedge clk);
              hold_off <= 1'b0;
            end
            repeat (30) send_point(18'($urandom), 18'($urandom));
          join
        end
        if ($urandom_range(0, 3) != 0) idle_gap();
      end
      in_valid <= 1'b0;
      drain();
    end

    gen_done <= 1'b1;
    drain();
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
